@@ rtl/cqdm_pkg.sv @@
package cqdm_pkg;

   // Storage depth of the ring and the widths that follow from it.
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   // Action codes carried on the request side.
   localparam logic [2:0] ACT_ENQUEUE     = 3'd0;
   localparam logic [2:0] ACT_DEQUEUE     = 3'd1;
   localparam logic [2:0] ACT_PEEK_OLDEST = 3'd2;
   localparam logic [2:0] ACT_PEEK_NEWEST = 3'd3;
   localparam logic [2:0] ACT_DRAIN_MIN   = 3'd4;

   // Status codes carried on the response side.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // Starting value of the minimum search.
   localparam logic signed [VAL_W-1:0] MIN_SEED = 32'sd99999;

   // Next slot index, wrapping at the programmed capacity.
   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(idx) + CNT_W'(1);
      return (n >= cap) ? '0 : n[IDX_W-1:0];
   endfunction

   // Previous slot index, wrapping at the programmed capacity.
   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] m;
      m = cap - CNT_W'(1);
      return (idx == '0) ? m[IDX_W-1:0] : idx - IDX_W'(1);
   endfunction

endpackage

@@ rtl/cqdm_ram.sv @@
module cqdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/circular_queue_with_drain_min_top.sv @@
// Ring-buffer FIFO of signed 32-bit values with a programmable capacity (1 to
// the storage depth, written through csr_wr_en/csr_wr_data while the queue is
// empty; the write also sends both pointers back to slot 0). Each request beat
// carries one action: enqueue, dequeue, peek at the oldest or newest entry, or
// drain the queue returning the least of 99999 and every drained entry. Every
// response beat carries the value, a status, the entry count and the full and
// empty flags after the action. Items are handled one at a time. Enqueue, any
// error and unknown actions produce their response in the cycle after the request
// is accepted; dequeue and both peeks pass through the S_READ state first, as the
// slot memory's read data is registered; a drain stays in S_DRAIN for one memory
// read per entry. A new request is taken while the sequencer is idle and the
// response register is free or is being emptied in the same cycle.
module circular_queue_with_drain_min_top (
   input  logic                       clock,
   input  logic                       reset,
   // Configuration: capacity.
   input  logic                       csr_wr_en,
   input  logic [cqdm_pkg::CNT_W-1:0] csr_wr_data,
   // Requests.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] push_value
   input  logic [2:0]                 req_tuser,   // [2:0] action
   // Responses.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [39:0]                rsp_tdata,   // [31:0] result_value,
                                                   // [36:32] entries_held,
                                                   // [37] is_full, [38] is_empty
   output logic [1:0]                 rsp_tuser    // [1:0] status
);

   import cqdm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_DRAIN
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        cap_ff, cap_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    deq_ff, deq_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic [2:0]              action;
   logic                    wr_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [VAL_W-1:0]        rd_data;
   logic signed [VAL_W-1:0] cand_min;

   assign action     = req_tuser;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Slot memory: enqueue writes at the tail, reads follow the FSM.
   assign wr_en = accept && (action == ACT_ENQUEUE) && (count_ff < cap_ff);

   always_comb begin
      if (state_ff == S_DRAIN) begin
         rd_addr = head_ff;
      end else if (action == ACT_PEEK_NEWEST) begin
         rd_addr = idx_prev(tail_ff, cap_ff);
      end else begin
         rd_addr = head_ff;
      end
   end

   cqdm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Running minimum including the entry that just came out of memory.
   assign cand_min = ($signed(rd_data) < min_ff) ? $signed(rd_data) : min_ff;

   // Next-state logic for the sequencer, pointers and response register.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      left_in       = left_ff;
      deq_in        = deq_ff;
      min_in        = min_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_value_in  = '0;
               rsp_status_in = STAT_OK;
               case (action)
                  ACT_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= cap_ff) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        tail_in  = idx_next(tail_ff, cap_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_DEQUEUE, ACT_PEEK_OLDEST, ACT_PEEK_NEWEST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        deq_in   = (action == ACT_DEQUEUE);
                        state_in = S_READ;
                     end
                  end
                  ACT_DRAIN_MIN: begin
                     min_in = MIN_SEED;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = MIN_SEED;
                        head_in      = tail_ff;
                     end else begin
                        head_in  = idx_next(head_ff, cap_ff);
                        left_in  = count_ff;
                        state_in = S_DRAIN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end else if (csr_wr_en && (count_ff == '0)) begin
               // Capacity is saturated into 1..DEPTH; pointers restart.
               if (csr_wr_data == '0) begin
                  cap_in = CNT_W'(1);
               end else if (csr_wr_data > CNT_W'(DEPTH)) begin
                  cap_in = CNT_W'(DEPTH);
               end else begin
                  cap_in = csr_wr_data;
               end
               head_in = '0;
               tail_in = '0;
            end
         end

         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            if (deq_ff) begin
               head_in  = idx_next(head_ff, cap_ff);
               count_in = count_ff - CNT_W'(1);
            end
            state_in = S_IDLE;
         end

         S_DRAIN: begin
            // One entry arrives per cycle; the next read is already issued.
            min_in  = cand_min;
            head_in = idx_next(head_ff, cap_ff);
            left_in = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = cand_min;
               head_in      = tail_ff;
               count_in     = '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      deq_ff        <= deq_in;
      min_ff        <= min_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Count and flags reflect the queue after the action being reported.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, (count_ff == '0), (count_ff == cap_ff), count_ff, rsp_value_ff};

endmodule

@@ bench/tb_top.sv @@
module tb_top;
   import cqdm_pkg::*;

   // Action codes that the block treats as no-ops.
   localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;

   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 100;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [2:0]        action;
      logic [VAL_W-1:0]  push;
   } queue_request_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [1:0]              status;
      logic [CNT_W-1:0]        held;
      logic                    full;
      logic                    empty;
   } queue_reply_type;

   // Block ports; every input starts at a known value.
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]  csr_wr_data = '0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;
   logic [2:0]        req_tuser   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [39:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;

   // Shadow copy of the ring, its pointers and the programmed capacity.
   logic signed [VAL_W-1:0] shadow_slot [DEPTH];
   logic [IDX_W-1:0]        shadow_head = '0;
   logic [IDX_W-1:0]        shadow_tail = '0;
   logic [CNT_W-1:0]        shadow_count = '0;
   logic [CNT_W-1:0]        shadow_cap = CNT_W'(DEPTH);

   queue_request_type queued_requests [$];
   queue_reply_type   predicted_replies [$];
   queue_request_type next_req;
   queue_reply_type   got_reply;
   queue_reply_type   want_reply;

   int idle_pct = 12;
   int send_gap = 0;
   int recv_stall = 0;
   int mismatch_count = 0;
   int replies_seen = 0;
   int full_replies = 0;
   int empty_replies = 0;
   int capacity_writes = 0;
   int accepted_by_action [8];

   circular_queue_with_drain_min_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Ring index one step forward, wrapping at the programmed capacity.
   function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] slot);
      return (int'(slot) + 1 >= int'(shadow_cap)) ? '0 : slot + 1'b1;
   endfunction

   // Apply one action to the shadow queue and record the reply it must give.
   function automatic void predict_reply(input logic [2:0] action,
                                         input logic [VAL_W-1:0] push);
      queue_reply_type r;
      r = '0;
      r.status = STAT_OK;
      case (action)
         ACT_ENQUEUE: begin
            if (shadow_count >= shadow_cap) begin
               r.status = STAT_FULL;
            end else begin
               shadow_slot[shadow_tail] = push;
               shadow_tail = ring_advance(shadow_tail);
               shadow_count++;
            end
         end
         ACT_DEQUEUE: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.value = shadow_slot[shadow_head];
               shadow_head = ring_advance(shadow_head);
               shadow_count--;
            end
         end
         ACT_PEEK_OLDEST: begin
            if (shadow_count == 0) r.status = STAT_EMPTY;
            else r.value = shadow_slot[shadow_head];
         end
         ACT_PEEK_NEWEST: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (shadow_tail == 0) begin
               r.value = shadow_slot[IDX_W'(shadow_cap - 1'b1)];
            end else begin
               r.value = shadow_slot[shadow_tail - 1'b1];
            end
         end
         ACT_DRAIN_MIN: begin
            // Walk every live entry from the oldest, keeping the signed minimum.
            r.value = MIN_SEED;
            while (shadow_count != 0) begin
               if (shadow_slot[shadow_head] < r.value) r.value = shadow_slot[shadow_head];
               shadow_head = ring_advance(shadow_head);
               shadow_count--;
            end
            shadow_head = shadow_tail;
         end
         default: begin
         end
      endcase
      r.held  = shadow_count;
      r.full  = (shadow_count == shadow_cap);
      r.empty = (shadow_count == 0);
      predicted_replies.push_back(r);
   endfunction

   function automatic void add_request(input logic [2:0] action, input logic [VAL_W-1:0] push);
      queue_request_type q;
      q.action = action;
      q.push = push;
      queued_requests.push_back(q);
   endfunction

   // Mostly uniform values, with the signed extremes and the values around the
   // minimum seed mixed in.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return MIN_SEED + $urandom_range(0, 2) - 1;
         default: return $urandom;
      endcase
   endfunction

   // Write the capacity register; the queue side must be quiet.
   task automatic program_capacity(input logic [CNT_W-1:0] setting);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // A write only takes effect on an empty queue; it saturates into range
      // and sends both pointers back to the first slot.
      if (shadow_count == 0) begin
         if (setting == 0) shadow_cap = CNT_W'(1);
         else if (setting > DEPTH) shadow_cap = CNT_W'(DEPTH);
         else shadow_cap = setting;
         shadow_head = '0;
         shadow_tail = '0;
      end
      capacity_writes++;
      @(negedge clock);
   endtask

   // Wait until every request has gone in and every reply has come back.
   task automatic wait_quiet();
      while (queued_requests.size() != 0 || req_tvalid || send_gap > 0 ||
             predicted_replies.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Random phase built from fill runs, emptying runs, mixed runs and drains.
   task automatic plan_random_phase(input int budget);
      int made;
      int len;
      int pick;
      int r;
      logic [2:0] act;
      made = 0;
      while (made < budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            len = $urandom_range(1, shadow_cap + 2);
            repeat (len) begin
               if ($urandom_range(0, 7) != 0) add_request(ACT_ENQUEUE, pick_value());
               else add_request($urandom_range(0, 1) ? ACT_PEEK_OLDEST : ACT_PEEK_NEWEST,
                                pick_value());
            end
         end else if (pick < 7) begin
            len = $urandom_range(1, shadow_cap + 2);
            repeat (len) begin
               if ($urandom_range(0, 7) != 0) add_request(ACT_DEQUEUE, pick_value());
               else add_request($urandom_range(0, 1) ? ACT_PEEK_OLDEST : ACT_PEEK_NEWEST,
                                pick_value());
            end
         end else if (pick < 9) begin
            len = $urandom_range(4, 12);
            repeat (len) begin
               r = $urandom_range(0, 19);
               if (r < 7) act = ACT_ENQUEUE;
               else if (r < 12) act = ACT_DEQUEUE;
               else if (r < 15) act = ACT_PEEK_OLDEST;
               else if (r < 18) act = ACT_PEEK_NEWEST;
               else if (r < 19) act = ACT_DRAIN_MIN;
               else act = 3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
               add_request(act, pick_value());
            end
         end else begin
            len = 1;
            add_request(ACT_DRAIN_MIN, pick_value());
         end
         made += len;
      end
      // Usually leave the queue empty so the next capacity write takes effect.
      if ($urandom_range(0, 4) != 0) add_request(ACT_DRAIN_MIN, pick_value());
   endtask

   // Request driver: predicts on each accepted beat, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_by_action[req_tuser]++;
            predict_reply(req_tuser, req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if ($urandom_range(1, 100) <= idle_pct) begin
               send_gap = $urandom_range(0, 6);
               req_tvalid <= 1'b0;
            end else begin
               next_req = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_req.action;
               req_tdata <= next_req.push;
            end
         end
      end
   end

   // Reply monitor: compares each accepted beat with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_reply.value  = rsp_tdata[31:0];
            got_reply.held   = rsp_tdata[36:32];
            got_reply.full   = rsp_tdata[37];
            got_reply.empty  = rsp_tdata[38];
            got_reply.status = rsp_tuser;
            replies_seen++;
            if (got_reply.status == STAT_FULL) full_replies++;
            if (got_reply.status == STAT_EMPTY) empty_replies++;
            if (predicted_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("Reply beat %0d arrived with nothing pending: value %0d status %0d",
                           replies_seen, got_reply.value, got_reply.status);
            end else begin
               want_reply = predicted_replies.pop_front();
               if (got_reply !== want_reply) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"Reply beat %0d mismatch: expected value %0d status %0d ",
                               "held %0d full %b empty %b, got value %0d status %0d ",
                               "held %0d full %b empty %b"},
                              replies_seen, want_reply.value, want_reply.status,
                              want_reply.held, want_reply.full, want_reply.empty,
                              got_reply.value, got_reply.status, got_reply.held,
                              got_reply.full, got_reply.empty);
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(1, 100) <= idle_pct) begin
            recv_stall = $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      logic [CNT_W-1:0] setting;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty queue at full capacity: every read error, the reserved codes and
      // a drain that returns the seed.
      add_request(ACT_DEQUEUE, 32'h0);
      add_request(ACT_PEEK_OLDEST, 32'hFFFF_FFFF);
      add_request(ACT_PEEK_NEWEST, 32'h0);
      add_request(ACT_DRAIN_MIN, 32'h0);
      for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
         add_request(3'(a), 32'h1234_5678);
      // Signed extremes, peeks at both ends, then a drain down to the most
      // negative value.
      add_request(ACT_ENQUEUE, 32'h7FFF_FFFF);
      add_request(ACT_ENQUEUE, 32'h8000_0000);
      add_request(ACT_ENQUEUE, MIN_SEED + 1);
      add_request(ACT_PEEK_OLDEST, 32'h0);
      add_request(ACT_PEEK_NEWEST, 32'h0);
      add_request(ACT_DEQUEUE, 32'h0);
      add_request(ACT_DRAIN_MIN, 32'h0);
      // Every entry above the seed: the drain returns the seed itself.
      add_request(ACT_ENQUEUE, MIN_SEED + 1);
      add_request(ACT_ENQUEUE, 32'd123456);
      add_request(ACT_DRAIN_MIN, 32'h0);
      wait_quiet();

      // A zero capacity saturates to one entry.
      program_capacity('0);
      add_request(ACT_ENQUEUE, 32'hFFFF_FFFF);
      add_request(ACT_ENQUEUE, 32'd5);
      add_request(ACT_PEEK_NEWEST, 32'h0);
      add_request(ACT_DEQUEUE, 32'h0);
      add_request(ACT_ENQUEUE, 32'h0);
      wait_quiet();

      // A write while an entry is held must be ignored.
      program_capacity('1);
      add_request(ACT_ENQUEUE, 32'd77);
      add_request(ACT_DEQUEUE, 32'h0);
      wait_quiet();

      // Random phases over a spread of capacities; phases 1, 4 and 7 and the last one run flat out.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: setting = 5'd2;
            1: setting = 5'd1;
            2: setting = 5'd16;
            3: setting = 5'd0;
            4: setting = 5'd3;
            5: setting = 5'd17;
            6: setting = 5'd31;
            7: setting = 5'd7;
            default: setting = 5'($urandom_range(1, 31));
         endcase
         if (phase == RANDOM_PHASES - 1 || phase % 3 == 1) idle_pct = 0;
         else if (phase % 3 == 2) idle_pct = 35;
         else idle_pct = 12;
         program_capacity(setting);
         plan_random_phase(PHASE_ITEMS);
         wait_quiet();
      end

      // Allow for the longest drain before closing.
      repeat (DEPTH + 4) @(negedge clock);
      $display("Ran %0d enqueue, %0d dequeue, %0d peek, %0d drain and %0d reserved requests",
               accepted_by_action[ACT_ENQUEUE], accepted_by_action[ACT_DEQUEUE],
               accepted_by_action[ACT_PEEK_OLDEST] + accepted_by_action[ACT_PEEK_NEWEST],
               accepted_by_action[ACT_DRAIN_MIN],
               accepted_by_action[5] + accepted_by_action[6] + accepted_by_action[7]);
      $display("over %0d capacity writes; %0d replies checked (%0d full, %0d empty), %0d bad",
               capacity_writes, replies_seen, full_replies, empty_replies, mismatch_count);
      if (mismatch_count == 0 && predicted_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/cqdm_pkg.sv
rtl/cqdm_ram.sv
rtl/circular_queue_with_drain_min_top.sv
bench/tb_top.sv
